[hdl/set_assoc_lru_cache_lookup_core_assert.svh]
// ---------------------------------------------------------------------------
// assertion macros for the lru cache lookup core
// clocked on clk_i; the first form is quiet while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_CORE_ASSERT_SVH

// property checked outside reset
`define SALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked during reset as well
`define SALC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/salc_pkg.sv]
// ---------------------------------------------------------------------------
// salc_pkg
// shared types and constants of the lru cache lookup core
// ---------------------------------------------------------------------------
package salc_pkg;

  // payload widths
  localparam int CMD_W      = 2;
  localparam int ADDR_IN_W  = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CNT_W      = 32;
  localparam int STAMP_W    = 64;
  localparam int SETU_W     = 6;
  localparam int WAYU_W     = 3;
  localparam int OUT_RAW_W  = 2 + WAYU_W + SETU_W + 3 * CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_VICTIM,
    ST_READ
  } salc_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;        // latch command and address
    logic rd_en;          // read one set row
    logic rd_from_input;  // row address from the incoming address
    logic victim_init;    // start the lru scan
    logic victim_step;    // compare one more way
    logic commit;         // write the row back and load the result
    logic commit_victim;  // commit replaces the lru way
    logic is_last;        // result closes the input transaction
  } salc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic empty_found;
    logic victim_done;
    logic out_free;
    logic is_modify;
  } salc_sts_t;

endpackage

[hdl/set_assoc_lru_cache_lookup_core.sv]
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_core
// set-associative cache tag array with lru replacement
// ---------------------------------------------------------------------------
//  channel   direction  transaction                   payload
//  s_axis    in         one access command            tdata address, tuser command
//  m_axis    out        one result per access         tdata flags/way/set/totals, tlast
//  cfg       in         one register write            index, data
//
//  a hit or a fill into a free way: accept with the set row read, then tag
//  compare and row write-back in ST_LOOKUP, held while a result still waits
//  a full set adds an lru scan over the used ways, one stamp compare a cycle
//  a modify makes two accesses; the second re-reads the row and compares again
//  reset empties the cache at once through one row-written flag per set
//  a result waiting on m_axis holds only the next commit, not the accept
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_lookup_core #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // access commands
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [salc_pkg::ADDR_IN_W-1:0]    s_axis_tdata_i,   // address
  input  logic [salc_pkg::CMD_W-1:0]        s_axis_tuser_i,   // command
  // results
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // hit, evicted, way_used[2:0], set_used[5:0], total_hits[31:0],
  // total_misses[31:0], total_evictions[31:0], zero padding
  output logic [salc_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import salc_pkg::*;

  salc_cmd_t ctrl;
  salc_sts_t sts;

  // registers always writable; user changes them only while idle (not enforced)
  assign cfg_ready_o = 1'b1;

  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .ctrl_o     (ctrl)
  );

  salc_dpath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_cmd_i    (s_axis_tuser_i),
    .in_addr_i   (s_axis_tdata_i),
    .ctrl_i      (ctrl),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

[hdl/salc_dpath.sv]
// ---------------------------------------------------------------------------
// salc_dpath
// configuration, tag/stamp/valid row memories, lookup, lru scan, totals
// and the result register
// ---------------------------------------------------------------------------
module salc_dpath #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [salc_pkg::CMD_W-1:0]        in_cmd_i,
  input  logic [salc_pkg::ADDR_IN_W-1:0]    in_addr_i,
  input  salc_pkg::salc_cmd_t               ctrl_i,
  output salc_pkg::salc_sts_t               sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [salc_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic                              out_last_o
);
  import salc_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAYW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CW       = $clog2(MAX_WAYS + 1);

  typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_row_t;
  typedef logic [MAX_WAYS-1:0][STAMP_W-1:0]    stamp_row_t;
  typedef logic [MAX_WAYS-1:0]                 vld_row_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // configuration registers
  logic [2:0] set_bits_q;
  logic [5:0] block_bits_q;
  logic [3:0] ways_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd1;
      block_bits_q <= 6'd4;
      ways_used_q  <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SET_BITS:   set_bits_q   <= cfg_data_i[2:0];
        REG_BLOCK_BITS: block_bits_q <= cfg_data_i[5:0];
        REG_WAYS_USED:  ways_used_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // effective set bits and ways
  logic [3:0]              sb_eff;
  logic [4:0]              wu5;
  logic [CW-1:0]           ways_eff;
  logic [MAX_SET_BITS-1:0] set_mask;

  always_comb begin
    sb_eff = (32'(set_bits_q) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, set_bits_q};
    wu5    = {1'b0, ways_used_q};
    if (wu5 == 5'd0) begin
      ways_eff = CW'(1);
    end else if (32'(wu5) > MAX_WAYS) begin
      ways_eff = CW'(MAX_WAYS);
    end else begin
      ways_eff = CW'(wu5);
    end
    set_mask = ~({MAX_SET_BITS{1'b1}} << sb_eff);
  end

  // captured access
  logic [CMD_W-1:0]      cmd_q;
  logic [ADDR_WIDTH-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= in_cmd_i;
      addr_q <= in_addr_i[ADDR_WIDTH-1:0];
    end
  end

  // address split
  logic [ADDR_WIDTH-1:0]   rest_in, rest_st, cur_tag;
  logic [MAX_SET_BITS-1:0] set_in, set_st, rd_set;

  always_comb begin
    rest_in = in_addr_i[ADDR_WIDTH-1:0] >> block_bits_q;
    rest_st = addr_q >> block_bits_q;
    set_in  = rest_in[MAX_SET_BITS-1:0] & set_mask;
    set_st  = rest_st[MAX_SET_BITS-1:0] & set_mask;
    cur_tag = rest_st >> sb_eff;
    rd_set  = ctrl_i.rd_from_input ? set_in : set_st;
  end

  // row memories and their row-written flags
  tag_row_t   tag_mem   [NUM_SETS];
  stamp_row_t stamp_mem [NUM_SETS];
  vld_row_t   vld_mem   [NUM_SETS];
  logic [NUM_SETS-1:0] row_valid_q;

  tag_row_t            tag_rd_q, tag_wr;
  stamp_row_t          stamp_rd_q, stamp_wr;
  vld_row_t            vld_rd_q, vld_wr, valid_row;
  logic                row_ok_q;
  logic [MAX_SET_BITS-1:0] set_q;
  logic [WAYW-1:0]     way_sel;
  logic [STAMP_W-1:0]  stamp_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      tag_rd_q   <= tag_mem[rd_set];
      stamp_rd_q <= stamp_mem[rd_set];
      vld_rd_q   <= vld_mem[rd_set];
      set_q      <= rd_set;
    end
    if (ctrl_i.commit) begin
      tag_mem[set_q]   <= tag_wr;
      stamp_mem[set_q] <= stamp_wr;
      vld_mem[set_q]   <= vld_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      row_ok_q    <= 1'b0;
    end else begin
      if (ctrl_i.rd_en) begin
        row_ok_q <= row_valid_q[rd_set];
      end
      if (ctrl_i.commit) begin
        row_valid_q[set_q] <= 1'b1;
      end
    end
  end

  // tag match and first free way
  logic            hit, empty_found;
  logic [WAYW-1:0] hit_way, empty_way;
  logic            in_use;

  always_comb begin
    valid_row   = row_ok_q ? vld_rd_q : '0;
    hit         = 1'b0;
    empty_found = 1'b0;
    hit_way     = '0;
    empty_way   = '0;
    in_use      = 1'b0;
    // scan downwards so the lowest index wins
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      in_use = CW'(w) < ways_eff;
      if (in_use && valid_row[w] && (tag_rd_q[w] == cur_tag)) begin
        hit     = 1'b1;
        hit_way = WAYW'(w);
      end
      if (in_use && !valid_row[w]) begin
        empty_found = 1'b1;
        empty_way   = WAYW'(w);
      end
    end
  end

  // lru scan, one way a cycle
  logic [STAMP_W-1:0] best_q, cand;
  logic [WAYW-1:0]    best_way_q;
  logic [CW-1:0]      vidx_q;

  assign cand = stamp_rd_q[vidx_q[WAYW-1:0]];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.victim_init) begin
      best_q     <= stamp_rd_q[0];
      best_way_q <= '0;
      vidx_q     <= CW'(1);
    end else if (ctrl_i.victim_step) begin
      if (cand < best_q) begin
        best_q     <= cand;
        best_way_q <= vidx_q[WAYW-1:0];
      end
      vidx_q <= vidx_q + 1'b1;
    end
  end

  // row write-back
  always_comb begin
    if (ctrl_i.commit_victim) begin
      way_sel = best_way_q;
    end else if (hit) begin
      way_sel = hit_way;
    end else begin
      way_sel = empty_way;
    end
    tag_wr            = tag_rd_q;
    stamp_wr          = stamp_rd_q;
    vld_wr            = valid_row;
    tag_wr[way_sel]   = cur_tag;
    stamp_wr[way_sel] = stamp_q;
    vld_wr[way_sel]   = 1'b1;
  end

  // totals and access stamp
  logic [CNT_W-1:0] hits_q, misses_q, evicts_q;
  logic [CNT_W-1:0] hits_d, misses_d, evicts_d;
  logic             hit_now;

  always_comb begin
    hit_now  = hit && !ctrl_i.commit_victim;
    hits_d   = hit_now ? sat_inc(hits_q) : hits_q;
    misses_d = hit_now ? misses_q : sat_inc(misses_q);
    evicts_d = ctrl_i.commit_victim ? sat_inc(evicts_q) : evicts_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
      stamp_q  <= STAMP_W'(1);
    end else if (ctrl_i.commit) begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
      stamp_q  <= stamp_q + 1'b1;
    end
  end

  // result register
  logic [WAYW+WAYU_W-1:0]          way_ext;
  logic [MAX_SET_BITS+SETU_W-1:0]  set_ext;
  logic                            out_valid_q, out_last_q;
  logic [OUT_DATA_W-1:0]           out_data_q;

  assign way_ext = {{WAYU_W{1'b0}}, way_sel};
  assign set_ext = {{SETU_W{1'b0}}, set_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      out_data_q <= {{OUT_PAD_W{1'b0}}, evicts_d, misses_d, hits_d,
                     set_ext[SETU_W-1:0], way_ext[WAYU_W-1:0],
                     ctrl_i.commit_victim, hit_now};
      out_last_q <= ctrl_i.is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  assign sts_o.hit         = hit;
  assign sts_o.empty_found = empty_found;
  assign sts_o.victim_done = vidx_q >= ways_eff;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.is_modify   = cmd_q == CMD_MODIFY;

endmodule

[hdl/salc_ctrl.sv]
// ---------------------------------------------------------------------------
// salc_ctrl
// sequencer: accept, set row read, lookup, lru scan, commit
// ---------------------------------------------------------------------------
module salc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  salc_pkg::salc_sts_t sts_i,
  output salc_pkg::salc_cmd_t ctrl_o
);
  import salc_pkg::*;

  salc_state_e state_q, state_d;
  logic        phase_q, phase_d;   // second access of a modify
  logic        last_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    last_acc   = !(sts_i.is_modify && !phase_q);
    ctrl_o.is_last = last_acc;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture       = 1'b1;
          ctrl_o.rd_en         = 1'b1;
          ctrl_o.rd_from_input = 1'b1;
          phase_d              = 1'b0;
          state_d              = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts_i.hit || sts_i.empty_found) begin
          if (sts_i.out_free) begin
            ctrl_o.commit = 1'b1;
            phase_d       = 1'b1;
            state_d       = last_acc ? ST_IDLE : ST_READ;
          end
        end else begin
          ctrl_o.victim_init = 1'b1;
          state_d            = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        if (!sts_i.victim_done) begin
          ctrl_o.victim_step = 1'b1;
        end else if (sts_i.out_free) begin
          ctrl_o.commit        = 1'b1;
          ctrl_o.commit_victim = 1'b1;
          phase_d              = 1'b1;
          state_d              = last_acc ? ST_IDLE : ST_READ;
        end
      end
      ST_READ: begin
        ctrl_o.rd_en = 1'b1;
        state_d      = ST_LOOKUP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/salc_checker.sv]
// ---------------------------------------------------------------------------
// salc_checker
// port-level checks on the lru cache lookup core, bound to the top level
// ---------------------------------------------------------------------------
`include "set_assoc_lru_cache_lookup_core_assert.svh"

module salc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [salc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import salc_pkg::*;

  localparam int EVS_LSB = 2 + WAYU_W + SETU_W + 2 * CNT_W;

  logic             in_acc, out_stall, res_hit, res_evict;
  logic [CNT_W-1:0] res_evicts;

  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall  = m_axis_tvalid_o && !m_axis_tready_i;
  assign res_hit    = m_axis_tdata_o[0];
  assign res_evict  = m_axis_tdata_o[1];
  assign res_evicts = m_axis_tdata_o[EVS_LSB +: CNT_W];

  // a stalled result keeps its payload
  `SALC_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stall broken")

  // no result is offered once a reset cycle has passed
  `SALC_ASSERT_RST(a_rst_quiet, !rst_ni |=> !m_axis_tvalid_o, "result offered in reset")

  // an accepted command keeps the core busy for the following cycle
  `SALC_ASSERT(a_busy_after_accept, in_acc |=> !s_axis_tready_o, "accepted back to back")

  // an access is never both a hit and an eviction
  `SALC_ASSERT(a_hit_xor_evict, m_axis_tvalid_o |-> !(res_hit && res_evict), "hit and eviction")

  // an eviction is always reflected in the running eviction total
  `SALC_ASSERT(a_evict_counted, m_axis_tvalid_o && res_evict |-> res_evicts != '0, "zero evictions")

endmodule

bind set_assoc_lru_cache_lookup_core salc_checker u_salc_checker (.*);
